// ----- sv/trbr_pkg.sv -----
// Shared types, constants and helpers for the tile background pixel renderer.
package trbr_pkg;

  // Video memory layout: tile data in the low 4 KiB, tile map at 0x1800
  localparam int unsigned MAP_ROW_TILES   = 32;
  localparam int unsigned MAP_BYTES       = MAP_ROW_TILES * MAP_ROW_TILES;
  localparam int unsigned MAP_ADDR_W      = $clog2(MAP_BYTES);
  localparam int unsigned TILE_DATA_BYTES = 4096;
  localparam int unsigned TILE_BANK_DEPTH = TILE_DATA_BYTES / 2;
  localparam int unsigned BANK_ADDR_W     = $clog2(TILE_BANK_DEPTH);
  localparam logic [2:0]  MAP_REGION      = 3'b110;

  localparam int unsigned TDATA_IN_W  = 40;
  localparam int unsigned TDATA_OUT_W = 32;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  // One accepted request
  typedef struct packed {
    cmd_e        cmd;
    logic [12:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
  } req_t;

  // Both bit-plane bytes of one tile row for a render
  typedef struct packed {
    logic       vld;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] lo;
    logic [7:0] hi;
  } tile_row_t;

  // One finished pixel
  typedef struct packed {
    logic       vld;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] color;
    logic [7:0] shade;
  } pixel_t;

  // Gray level of a color index, index times 85
  function automatic logic [7:0] shade_of(input logic [1:0] color);
    logic [7:0] s;
    case (color)
      2'd0:    s = 8'd0;
      2'd1:    s = 8'd85;
      2'd2:    s = 8'd170;
      2'd3:    s = 8'd255;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/trbr_ram.sv -----
// Generic single-port RAM with registered read and clock enable.
module trbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/trbr_fetch.sv -----
// Request stage, tile map lookup and banked tile row fetch.
module trbr_fetch (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                req_vld_i,
  input  trbr_pkg::req_t      req_i,
  output trbr_pkg::tile_row_t row_o
);

  logic                             s0_vld_q;
  trbr_pkg::req_t                   s0_req_q;
  logic                             s1_vld_q;
  trbr_pkg::req_t                   s1_req_q;
  logic                             s2_vld_d, s2_vld_q;
  logic [7:0]                       s2_x_q, s2_y_q;

  logic                             s0_wr;
  logic                             map_we;
  logic [trbr_pkg::MAP_ADDR_W-1:0]  map_addr;
  logic [7:0]                       map_rdata;

  logic                             s1_wr;
  logic                             even_we, odd_we;
  logic [trbr_pkg::BANK_ADDR_W-1:0] bank_addr;
  logic [7:0]                       lo_rdata, hi_rdata;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s0_vld_q <= req_vld_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s2_vld_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_req_q <= req_i;
      s1_req_q <= s0_req_q;
      s2_x_q   <= s1_req_q.screen_x;
      s2_y_q   <= s1_req_q.screen_y;
    end
  end

  // Stage 0: tile map write or lookup of row y/8, column x/8
  assign s0_wr    = (s0_req_q.cmd == trbr_pkg::CMD_WRITE);
  assign map_we   = s0_vld_q && s0_wr && (s0_req_q.mem_address[12:10] == trbr_pkg::MAP_REGION);
  assign map_addr = s0_wr ? s0_req_q.mem_address[trbr_pkg::MAP_ADDR_W-1:0]
                          : {s0_req_q.screen_y[7:3], s0_req_q.screen_x[7:3]};

  trbr_ram #(
    .WIDTH (8),
    .DEPTH (trbr_pkg::MAP_BYTES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (s0_req_q.mem_data),
    .rdata_o (map_rdata)
  );

  // Stage 1: tile data write or fetch of both planes; even bytes low, odd bytes high
  assign s1_wr     = (s1_req_q.cmd == trbr_pkg::CMD_WRITE);
  assign even_we   = s1_vld_q && s1_wr && !s1_req_q.mem_address[12] &&
                     !s1_req_q.mem_address[0];
  assign odd_we    = s1_vld_q && s1_wr && !s1_req_q.mem_address[12] &&
                     s1_req_q.mem_address[0];
  assign bank_addr = s1_wr ? s1_req_q.mem_address[trbr_pkg::BANK_ADDR_W:1]
                           : {map_rdata, s1_req_q.screen_y[2:0]};
  assign s2_vld_d  = s1_vld_q && !s1_wr;

  trbr_ram #(
    .WIDTH (8),
    .DEPTH (trbr_pkg::TILE_BANK_DEPTH)
  ) u_lo_ram (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .we_i    (even_we),
    .addr_i  (bank_addr),
    .wdata_i (s1_req_q.mem_data),
    .rdata_o (lo_rdata)
  );

  trbr_ram #(
    .WIDTH (8),
    .DEPTH (trbr_pkg::TILE_BANK_DEPTH)
  ) u_hi_ram (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .we_i    (odd_we),
    .addr_i  (bank_addr),
    .wdata_i (s1_req_q.mem_data),
    .rdata_o (hi_rdata)
  );

  // Stage 2: hand the tile row to the pixel stage
  assign row_o.vld = s2_vld_q;
  assign row_o.x   = s2_x_q;
  assign row_o.y   = s2_y_q;
  assign row_o.lo  = lo_rdata;
  assign row_o.hi  = hi_rdata;

endmodule

// ----- sv/trbr_pixel.sv -----
// Bit selection from both planes and gray shade, registered.
module trbr_pixel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  trbr_pkg::tile_row_t row_i,
  output trbr_pkg::pixel_t    pix_o
);

  logic [2:0]       bit_sel;
  logic [1:0]       color;
  logic             vld_q;
  trbr_pkg::pixel_t pix_q;

  // Pick bit 7 - x%8 of each plane
  assign bit_sel = 3'd7 - row_i.x[2:0];
  assign color   = {row_i.hi[bit_sel], row_i.lo[bit_sel]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= row_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q.vld   <= row_i.vld;
      pix_q.x     <= row_i.x;
      pix_q.y     <= row_i.y;
      pix_q.color <= color;
      pix_q.shade <= trbr_pkg::shade_of(color);
    end
  end

  always_comb begin
    pix_o     = pix_q;
    pix_o.vld = vld_q;
  end

endmodule

// ----- sv/trbr_skid.sv -----
// Output skid buffer that decouples the pipeline enable from the sink ready.
module trbr_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trbr_pkg::pixel_t pix_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output trbr_pkg::pixel_t out_pix_o,
  output logic             full_o
);

  logic             skid_vld_q;
  trbr_pkg::pixel_t skid_pix_q;
  logic             capture;

  // Catch the presented pixel when the sink stalls and the pipeline moves on
  assign capture = !skid_vld_q && pix_i.vld && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (capture) begin
      skid_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      skid_pix_q <= pix_i;
    end
  end

  // Drain the skid entry first
  assign out_valid_o = skid_vld_q || pix_i.vld;
  assign out_pix_o   = skid_vld_q ? skid_pix_q : pix_i;
  assign full_o      = skid_vld_q;

endmodule

// ----- sv/tile_background_pixel_render_core.sv -----
// Top level of the tile background pixel renderer with its 8 KiB video address space (4 KiB tile data, 1 KiB tile map).
// Throughput: one request per cycle while the skid entry is free; the stages are request
// register, tile map RAM read, tile plane RAM read and pixel register, all moving on one enable.
// A write request takes its RAM slot in order with renders and returns no result.
// Reset clears all valid bits and the skid buffer; video memory is undefined until written.
module tile_background_pixel_render_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [12:0] mem_address, [20:13] mem_data, [28:21] screen_x, [36:29] screen_y
  input  logic [trbr_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] out_x, [15:8] out_y, [17:16] color_index, [25:18] gray_shade
  output logic [trbr_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

  trbr_pkg::req_t      req;
  trbr_pkg::tile_row_t row;
  trbr_pkg::pixel_t    pix;
  trbr_pkg::pixel_t    out_pix;
  logic                skid_full;
  logic                en;

  // Move the whole pipeline while the skid entry is free
  assign en            = !skid_full;
  assign s_axis_tready = en;

  // Unpack the request
  assign req.cmd         = trbr_pkg::cmd_e'(s_axis_tuser);
  assign req.mem_address = s_axis_tdata[12:0];
  assign req.mem_data    = s_axis_tdata[20:13];
  assign req.screen_x    = s_axis_tdata[28:21];
  assign req.screen_y    = s_axis_tdata[36:29];

  trbr_fetch u_fetch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .req_vld_i (s_axis_tvalid),
    .req_i     (req),
    .row_o     (row)
  );

  trbr_pixel u_pixel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .row_i  (row),
    .pix_o  (pix)
  );

  trbr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pix_o   (out_pix),
    .full_o      (skid_full)
  );

  // Pack the result
  assign m_axis_tdata = {6'd0, out_pix.shade, out_pix.color, out_pix.y, out_pix.x};

  // The skid entry fills only behind a stalled result
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid filled without a stalled result");

  // A valid pixel in the pixel stage holds while the skid entry is occupied
  a_pix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full && pix.vld) |=> $stable(pix))
    else $error("pixel stage moved during a stall");

  // A taken skid entry is empty in the next cycle
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full && m_axis_tready) |=> !skid_full)
    else $error("skid entry did not drain");

endmodule
